FILE: rtl/buffer_pool_clock_replacement_unit_assert.svh
`ifndef BUFFER_POOL_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH
`define BUFFER_POOL_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its condition
`define BPCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition
`define BPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bpcr_pkg.sv
`timescale 1ns / 1ps

package bpcr_pkg;

    // Field widths of the stream items
    localparam int FILE_W    = 8;
    localparam int BLOCK_W   = 16;
    localparam int TAG_W     = FILE_W + BLOCK_W;
    localparam int IDX_W     = 4;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STATUS_W + 1;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP      = 3'd0,
        CMD_SET_DIRTY   = 3'd1,
        CMD_SET_PIN     = 3'd2,
        CMD_FLUSH_FRAME = 3'd3,
        CMD_FLUSH_ALL   = 3'd4
    } t_cmd;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_HIT      = 2'd0;
    localparam t_status ST_MISS     = 2'd1;
    localparam t_status ST_NO_FRAME = 2'd2;
    localparam t_status ST_DONE     = 2'd3;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_ACCEPT     = 4'd1,
        OP_SET_FLAG   = 4'd2,
        OP_FLUSH_SEL  = 4'd3,
        OP_DONE_ZERO  = 4'd4,
        OP_LK_READ    = 4'd5,
        OP_LK_CHECK   = 4'd6,
        OP_SWEEP_STEP = 4'd7,
        OP_VIC_READ   = 4'd8,
        OP_FILL       = 4'd9,
        OP_FA_CHECK   = 4'd10,
        OP_EMIT       = 4'd11
    } t_dp_op;

    // Datapath status seen by the controller
    typedef struct packed {
        t_cmd cmd;
        logic hit;
        logic free_avail;
        logic scan_last;
        logic victim;
        logic sweep_end;
        logic fa_dirty;
        logic res_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/bpcr_ctrl.sv
`timescale 1ns / 1ps

module bpcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  bpcr_pkg::t_dp_stat i_stat,
    output bpcr_pkg::t_dp_op   o_op
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_LK_RD  = 9'b000000100,
        S_LK_CHK = 9'b000001000,
        S_SWEEP  = 9'b000010000,
        S_VIC_RD = 9'b000100000,
        S_FILL   = 9'b001000000,
        S_FA_CHK = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a new item only between requests
    assign o_s_tready = (r_state == S_IDLE);

    // Sequence the datapath operations
    always_comb begin
        n_state = r_state;
        o_op    = bpcr_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_op    = bpcr_pkg::OP_ACCEPT;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    bpcr_pkg::CMD_LOOKUP: begin
                        n_state = S_LK_RD;
                    end
                    bpcr_pkg::CMD_SET_DIRTY, bpcr_pkg::CMD_SET_PIN: begin
                        o_op    = bpcr_pkg::OP_SET_FLAG;
                        n_state = S_EMIT;
                    end
                    bpcr_pkg::CMD_FLUSH_FRAME: begin
                        o_op    = bpcr_pkg::OP_FLUSH_SEL;
                        n_state = S_EMIT;
                    end
                    bpcr_pkg::CMD_FLUSH_ALL: begin
                        n_state = S_FA_CHK;
                    end
                    default: begin
                        o_op    = bpcr_pkg::OP_DONE_ZERO;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_LK_RD: begin
                o_op    = bpcr_pkg::OP_LK_READ;
                n_state = S_LK_CHK;
            end
            S_LK_CHK: begin
                o_op = bpcr_pkg::OP_LK_CHECK;
                if (i_stat.hit) begin
                    n_state = S_EMIT;
                end else if (i_stat.scan_last) begin
                    n_state = i_stat.free_avail ? S_FILL : S_SWEEP;
                end else begin
                    n_state = S_LK_RD;
                end
            end
            S_SWEEP: begin
                o_op = bpcr_pkg::OP_SWEEP_STEP;
                if (i_stat.victim) begin
                    n_state = S_VIC_RD;
                end else if (i_stat.sweep_end) begin
                    n_state = S_EMIT;
                end
            end
            S_VIC_RD: begin
                o_op    = bpcr_pkg::OP_VIC_READ;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_op    = bpcr_pkg::OP_FILL;
                n_state = S_EMIT;
            end
            S_FA_CHK: begin
                o_op = bpcr_pkg::OP_FA_CHECK;
                if (i_stat.fa_dirty || i_stat.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_op    = bpcr_pkg::OP_EMIT;
                    n_state = i_stat.res_last ? S_IDLE : S_FA_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/bpcr_datapath.sv
`timescale 1ns / 1ps

`include "buffer_pool_clock_replacement_unit_assert.svh"

module bpcr_datapath #(
    parameter int FRAMES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpcr_pkg::t_dp_op              i_op,
    input  logic [bpcr_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bpcr_pkg::FILE_W-1:0]   i_file_id,
    input  logic [bpcr_pkg::BLOCK_W-1:0]  i_block_id,
    input  logic [bpcr_pkg::IDX_W-1:0]    i_frame_index,
    input  logic                          i_flag_value,
    input  logic                          i_m_tready,
    output bpcr_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    output bpcr_pkg::t_status             o_status,
    output logic [bpcr_pkg::IDX_W-1:0]    o_frame_out,
    output logic                          o_writeback,
    output logic [bpcr_pkg::FILE_W-1:0]   o_wb_file_id,
    output logic [bpcr_pkg::BLOCK_W-1:0]  o_wb_block_id,
    output logic                          o_last
);

    localparam int HW = $clog2(FRAMES);
    localparam int PW = HW + 1;

    // Latched request
    bpcr_pkg::t_cmd                 r_cmd, n_cmd;
    logic [bpcr_pkg::FILE_W-1:0]    r_fid, n_fid;
    logic [bpcr_pkg::BLOCK_W-1:0]   r_bid, n_bid;
    logic [bpcr_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                           r_flag, n_flag;

    // Frame flags, clock hand and scan state
    logic [FRAMES-1:0]              r_valid, n_valid;
    logic [FRAMES-1:0]              r_dirty, n_dirty;
    logic [FRAMES-1:0]              r_pinned, n_pinned;
    logic [FRAMES-1:0]              r_ref, n_ref;
    logic [HW-1:0]                  r_hand, n_hand;
    logic [PW-1:0]                  r_ptr, n_ptr;
    logic [HW-1:0]                  r_sel, n_sel;
    logic                           r_free_found, n_free_found;

    // Pending result
    bpcr_pkg::t_status              r_res_status, n_res_status;
    logic [bpcr_pkg::IDX_W-1:0]     r_res_frame, n_res_frame;
    logic                           r_res_wb, n_res_wb;
    logic                           r_res_last, n_res_last;

    // Output register
    logic                           r_out_valid, n_out_valid;
    bpcr_pkg::t_status              r_out_status, n_out_status;
    logic [bpcr_pkg::IDX_W-1:0]     r_out_frame, n_out_frame;
    logic                           r_out_wb, n_out_wb;
    logic [bpcr_pkg::FILE_W-1:0]    r_out_fid, n_out_fid;
    logic [bpcr_pkg::BLOCK_W-1:0]   r_out_bid, n_out_bid;
    logic                           r_out_last, n_out_last;

    // Tag memory, one read port with registered data
    logic [bpcr_pkg::TAG_W-1:0]     r_tag_mem [FRAMES];
    logic [bpcr_pkg::TAG_W-1:0]     r_tag_q;
    logic                           rd_en;
    logic [HW-1:0]                  rd_addr;
    logic                           wr_en;

    logic [HW-1:0]                  ptr_idx;
    logic [HW-1:0]                  req_idx;
    logic                           idx_ok;
    logic [bpcr_pkg::TAG_W-1:0]     key;
    logic                           hit;
    logic                           scan_last;
    logic                           victim;
    logic                           sweep_end;
    logic [HW-1:0]                  hand_next;
    logic [PW-1:0]                  ptr_inc;
    logic [FRAMES-1:0]              dirty_above;
    logic                           fa_more;

    // Decode scan and sweep conditions
    assign ptr_idx   = r_ptr[HW-1:0];
    assign req_idx   = HW'(r_idx);
    assign idx_ok    = (int'(r_idx) < FRAMES);
    assign key       = {r_fid, r_bid};
    assign hit       = r_valid[ptr_idx] && (r_tag_q == key);
    assign scan_last = (r_ptr == PW'(FRAMES - 1));
    assign victim    = !(r_ref[r_hand] || r_pinned[r_hand]);
    assign sweep_end = (r_ptr == PW'(2 * FRAMES - 1));
    assign hand_next = (r_hand == HW'(FRAMES - 1)) ? '0 : r_hand + HW'(1);
    assign ptr_inc   = r_ptr + PW'(1);

    // Find dirty frames beyond the scan pointer
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            dirty_above[i] = r_dirty[i] && (i > int'(ptr_idx));
        end
    end
    assign fa_more = |dirty_above;

    assign o_stat.cmd        = r_cmd;
    assign o_stat.hit        = hit;
    assign o_stat.free_avail = r_free_found || !r_valid[ptr_idx];
    assign o_stat.scan_last  = scan_last;
    assign o_stat.victim     = victim;
    assign o_stat.sweep_end  = sweep_end;
    assign o_stat.fa_dirty   = r_dirty[ptr_idx];
    assign o_stat.res_last   = r_res_last;
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    // Select the tag memory address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ptr_idx;
        wr_en   = (i_op == bpcr_pkg::OP_FILL);
        case (i_op)
            bpcr_pkg::OP_LK_READ: begin
                rd_en = 1'b1;
            end
            bpcr_pkg::OP_FA_CHECK: begin
                rd_en = 1'b1;
            end
            bpcr_pkg::OP_VIC_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_sel;
            end
            bpcr_pkg::OP_FLUSH_SEL: begin
                rd_en   = 1'b1;
                rd_addr = req_idx;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tag_mem[r_sel] <= key;
        end
        if (rd_en) begin
            r_tag_q <= r_tag_mem[rd_addr];
        end
    end

    // Apply the operation to flags, hand and pending result
    always_comb begin
        n_cmd        = r_cmd;
        n_fid        = r_fid;
        n_bid        = r_bid;
        n_idx        = r_idx;
        n_flag       = r_flag;
        n_valid      = r_valid;
        n_dirty      = r_dirty;
        n_pinned     = r_pinned;
        n_ref        = r_ref;
        n_hand       = r_hand;
        n_ptr        = r_ptr;
        n_sel        = r_sel;
        n_free_found = r_free_found;
        n_res_status = r_res_status;
        n_res_frame  = r_res_frame;
        n_res_wb     = r_res_wb;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_frame  = r_out_frame;
        n_out_wb     = r_out_wb;
        n_out_fid    = r_out_fid;
        n_out_bid    = r_out_bid;
        n_out_last   = r_out_last;
        case (i_op)
            bpcr_pkg::OP_ACCEPT: begin
                n_cmd        = bpcr_pkg::t_cmd'(i_cmd);
                n_fid        = i_file_id;
                n_bid        = i_block_id;
                n_idx        = i_frame_index;
                n_flag       = i_flag_value;
                n_ptr        = '0;
                n_free_found = 1'b0;
                n_res_wb     = 1'b0;
                n_res_last   = 1'b1;
            end
            bpcr_pkg::OP_SET_FLAG: begin
                if (idx_ok && r_valid[req_idx]) begin
                    if (r_cmd == bpcr_pkg::CMD_SET_DIRTY) begin
                        n_dirty[req_idx] = r_flag;
                    end else begin
                        n_pinned[req_idx] = r_flag;
                    end
                end
                n_res_status = bpcr_pkg::ST_DONE;
                n_res_frame  = r_idx;
            end
            bpcr_pkg::OP_FLUSH_SEL: begin
                if (idx_ok && r_dirty[req_idx]) begin
                    n_dirty[req_idx] = 1'b0;
                    n_res_wb         = 1'b1;
                end
                n_res_status = bpcr_pkg::ST_DONE;
                n_res_frame  = r_idx;
            end
            bpcr_pkg::OP_DONE_ZERO: begin
                n_res_status = bpcr_pkg::ST_DONE;
                n_res_frame  = '0;
            end
            bpcr_pkg::OP_LK_CHECK: begin
                if (hit) begin
                    n_ref[ptr_idx] = 1'b1;
                    n_res_status   = bpcr_pkg::ST_HIT;
                    n_res_frame    = bpcr_pkg::IDX_W'(ptr_idx);
                end else begin
                    // Remember the lowest free frame
                    if (!r_free_found && !r_valid[ptr_idx]) begin
                        n_free_found = 1'b1;
                        n_sel        = ptr_idx;
                    end
                    n_ptr = scan_last ? '0 : ptr_inc;
                end
            end
            bpcr_pkg::OP_SWEEP_STEP: begin
                n_hand = hand_next;
                n_ptr  = ptr_inc;
                if (victim) begin
                    n_sel    = r_hand;
                    n_res_wb = r_dirty[r_hand];
                end else begin
                    // Give a second chance and move on
                    n_ref[r_hand] = 1'b0;
                    if (sweep_end) begin
                        n_res_status = bpcr_pkg::ST_NO_FRAME;
                        n_res_frame  = '0;
                        n_res_wb     = 1'b0;
                    end
                end
            end
            bpcr_pkg::OP_FILL: begin
                n_valid[r_sel]  = 1'b1;
                n_dirty[r_sel]  = 1'b0;
                n_pinned[r_sel] = 1'b0;
                n_ref[r_sel]    = 1'b1;
                n_res_status    = bpcr_pkg::ST_MISS;
                n_res_frame     = bpcr_pkg::IDX_W'(r_sel);
            end
            bpcr_pkg::OP_FA_CHECK: begin
                if (r_dirty[ptr_idx]) begin
                    n_dirty[ptr_idx] = 1'b0;
                    n_res_status     = bpcr_pkg::ST_DONE;
                    n_res_frame      = bpcr_pkg::IDX_W'(ptr_idx);
                    n_res_wb         = 1'b1;
                    n_res_last       = !fa_more;
                end else if (scan_last) begin
                    n_res_status = bpcr_pkg::ST_DONE;
                    n_res_frame  = '0;
                    n_res_wb     = 1'b0;
                    n_res_last   = 1'b1;
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            bpcr_pkg::OP_EMIT: begin
                n_out_valid  = 1'b1;
                n_out_status = r_res_status;
                n_out_frame  = r_res_frame;
                n_out_wb     = r_res_wb;
                n_out_fid    = r_res_wb ? r_tag_q[bpcr_pkg::TAG_W-1:bpcr_pkg::BLOCK_W] : '0;
                n_out_bid    = r_res_wb ? r_tag_q[bpcr_pkg::BLOCK_W-1:0] : '0;
                n_out_last   = r_res_last;
                if (!r_res_last) begin
                    n_ptr = ptr_inc;
                end
            end
            default: begin
                n_out_last = r_out_last;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_dirty      <= '0;
            r_pinned     <= '0;
            r_ref        <= '0;
            r_hand       <= '0;
            r_ptr        <= '0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_dirty      <= n_dirty;
            r_pinned     <= n_pinned;
            r_ref        <= n_ref;
            r_hand       <= n_hand;
            r_ptr        <= n_ptr;
            r_free_found <= n_free_found;
            r_out_valid  <= n_out_valid;
        end
    end

    // Advance payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_fid        <= n_fid;
        r_bid        <= n_bid;
        r_idx        <= n_idx;
        r_flag       <= n_flag;
        r_sel        <= n_sel;
        r_res_status <= n_res_status;
        r_res_frame  <= n_res_frame;
        r_res_wb     <= n_res_wb;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_frame  <= n_out_frame;
        r_out_wb     <= n_out_wb;
        r_out_fid    <= n_out_fid;
        r_out_bid    <= n_out_bid;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_frame_out   = r_out_frame;
    assign o_writeback   = r_out_wb;
    assign o_wb_file_id  = r_out_fid;
    assign o_wb_block_id = r_out_bid;
    assign o_last        = r_out_last;

    // Only valid frames carry dirty, pin or reference bits
    `BPCR_ASSERT_NOW(a_flags_need_valid, 1'b1, ((r_dirty | r_pinned | r_ref) & ~r_valid) == '0, "flag set on invalid frame")
    // The hand always points at an existing frame
    `BPCR_ASSERT_NOW(a_hand_range, 1'b1, int'(r_hand) < FRAMES, "clock hand out of range")
    // Tags are zero in any result without writeback
    `BPCR_ASSERT_NOW(a_wb_tags_zero, r_out_valid && !r_out_wb, r_out_fid == '0 && r_out_bid == '0, "tags without writeback")
    // A fill leaves its frame valid and referenced
    `BPCR_ASSERT_NEXT(a_fill_marks, i_op == bpcr_pkg::OP_FILL, r_valid[r_sel] && r_ref[r_sel], "fill did not mark frame")

endmodule

FILE: rtl/buffer_pool_clock_replacement_unit.sv
// Page-frame tag table with clock (second-chance) replacement. One request is worked on at a
// time, and the next is taken as soon as the last result of the current one sits in the output
// register. Tags live in a memory with one registered read port, so the lookup scan reads a
// frame and then compares it before it moves on; a miss is filled from a free frame. When every
// frame is valid the clock hand then sweeps one frame a cycle for up to 2*FRAMES steps, and
// either evicts a frame or gives a "no frame" result. Set dirty, set pin, flush frame and
// unknown commands are decoded and give a single result. Flush all scans one frame a cycle,
// pausing while a result waits for the output register, and gives one result per dirty
// frame, or a single result when no frame is dirty. Any output stall delays the results.
`timescale 1ns / 1ps

module buffer_pool_clock_replacement_unit #(
    parameter int FRAMES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // file_id[7:0], block_id[23:8], frame_index[27:24], flag_value[28], zero[31:29]
    input  logic [bpcr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // cmd[2:0]
    input  logic [bpcr_pkg::CMD_W-1:0]         s_axis_tuser,
    // Result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // frame_out[3:0], wb_file_id[11:4], wb_block_id[27:12], zero[31:28]
    output logic [bpcr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0], writeback[2]
    output logic [bpcr_pkg::M_TUSER_W-1:0]     m_axis_tuser,
    output logic                               m_axis_tlast
);

    bpcr_pkg::t_dp_op               op;
    bpcr_pkg::t_dp_stat             stat;
    bpcr_pkg::t_status              status;
    logic [bpcr_pkg::IDX_W-1:0]     frame_out;
    logic                           writeback;
    logic [bpcr_pkg::FILE_W-1:0]    wb_file_id;
    logic [bpcr_pkg::BLOCK_W-1:0]   wb_block_id;

    bpcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    bpcr_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_cmd         (s_axis_tuser),
        .i_file_id     (s_axis_tdata[7:0]),
        .i_block_id    (s_axis_tdata[23:8]),
        .i_frame_index (s_axis_tdata[27:24]),
        .i_flag_value  (s_axis_tdata[28]),
        .i_m_tready    (m_axis_tready),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_frame_out   (frame_out),
        .o_writeback   (writeback),
        .o_wb_file_id  (wb_file_id),
        .o_wb_block_id (wb_block_id),
        .o_last        (m_axis_tlast)
    );

    // Pack the result item
    assign m_axis_tdata = {4'b0000, wb_block_id, wb_file_id, frame_out};
    assign m_axis_tuser = {writeback, status};

endmodule

FILE: sim/tb_buffer_pool_clock_replacement_unit.sv
`timescale 1ns / 1ps

module tb_buffer_pool_clock_replacement_unit;

    localparam int FRAMES       = 16;
    localparam int SWEEP_ROUNDS = 2;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 266;
    localparam int KEY_POOL     = 24;
    localparam int IDLE_PCT     = 37;
    localparam int CALM_FIRST   = 100;
    localparam int CALM_LAST    = 180;
    localparam int DRAIN_CYCLES = 4 * FRAMES + 40;
    localparam int REQ_FIELDS_W = bpcr_pkg::FILE_W + bpcr_pkg::BLOCK_W + bpcr_pkg::IDX_W + 1;

    // Command codes the block has no use for
    localparam logic [bpcr_pkg::CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [bpcr_pkg::CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        bpcr_pkg::t_status                status;
        logic [bpcr_pkg::IDX_W-1:0]       frame;
        logic                             wb;
        logic [bpcr_pkg::FILE_W-1:0]      wb_file;
        logic [bpcr_pkg::BLOCK_W-1:0]     wb_block;
        logic                             last;
    } t_reply;

    // Frame table with clock replacement, plus the replies it still owes
    class t_frame_table_model;
        bit                               valid    [FRAMES];
        bit                               dirty    [FRAMES];
        bit                               pinned   [FRAMES];
        bit                               refd     [FRAMES];
        logic [bpcr_pkg::FILE_W-1:0]      file_tag [FRAMES];
        logic [bpcr_pkg::BLOCK_W-1:0]     block_tag[FRAMES];
        int                               hand;
        t_reply                           owed_replies[$];
        int                               errors;

        function new();
            for (int i = 0; i < FRAMES; i++) begin
                valid[i]     = 1'b0;
                dirty[i]     = 1'b0;
                pinned[i]    = 1'b0;
                refd[i]      = 1'b0;
                file_tag[i]  = '0;
                block_tag[i] = '0;
            end
            hand   = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return owed_replies.size();
        endfunction

        function void owe(bpcr_pkg::t_status st, int fr, logic wb,
                          logic [bpcr_pkg::FILE_W-1:0] wf,
                          logic [bpcr_pkg::BLOCK_W-1:0] wbk, logic last);
            t_reply r;
            r.status   = st;
            r.frame    = bpcr_pkg::IDX_W'(fr);
            r.wb       = wb;
            r.wb_file  = wf;
            r.wb_block = wbk;
            r.last     = last;
            owed_replies.push_back(r);
        endfunction

        function void fill(int f, logic [bpcr_pkg::FILE_W-1:0] fid,
                           logic [bpcr_pkg::BLOCK_W-1:0] bid);
            valid[f]     = 1'b1;
            dirty[f]     = 1'b0;
            pinned[f]    = 1'b0;
            refd[f]      = 1'b1;
            file_tag[f]  = fid;
            block_tag[f] = bid;
        endfunction

        // Work out the replies to one accepted request
        function void note_request(logic [bpcr_pkg::CMD_W-1:0] cmd,
                                   logic [bpcr_pkg::FILE_W-1:0] fid,
                                   logic [bpcr_pkg::BLOCK_W-1:0] bid,
                                   logic [bpcr_pkg::IDX_W-1:0] idx,
                                   logic flag);
            int found;
            int h;
            int n;
            found = -1;
            case (cmd)
                bpcr_pkg::CMD_LOOKUP: begin
                    for (int i = 0; i < FRAMES && found < 0; i++)
                        if (valid[i] && file_tag[i] == fid && block_tag[i] == bid)
                            found = i;
                    if (found >= 0) begin
                        refd[found] = 1'b1;
                        owe(bpcr_pkg::ST_HIT, found, 1'b0, '0, '0, 1'b1);
                        return;
                    end
                    for (int i = 0; i < FRAMES && found < 0; i++)
                        if (!valid[i])
                            found = i;
                    if (found >= 0) begin
                        fill(found, fid, bid);
                        owe(bpcr_pkg::ST_MISS, found, 1'b0, '0, '0, 1'b1);
                        return;
                    end
                    // Sweep the hand: second chance for referenced or pinned frames
                    for (int s = 0; s < SWEEP_ROUNDS * FRAMES; s++) begin
                        h = hand;
                        if (refd[h] || pinned[h]) begin
                            refd[h] = 1'b0;
                            hand    = (h + 1) % FRAMES;
                        end else begin
                            if (dirty[h])
                                owe(bpcr_pkg::ST_MISS, h, 1'b1, file_tag[h], block_tag[h],
                                    1'b1);
                            else
                                owe(bpcr_pkg::ST_MISS, h, 1'b0, '0, '0, 1'b1);
                            fill(h, fid, bid);
                            hand = (h + 1) % FRAMES;
                            return;
                        end
                    end
                    owe(bpcr_pkg::ST_NO_FRAME, 0, 1'b0, '0, '0, 1'b1);
                end
                bpcr_pkg::CMD_SET_DIRTY, bpcr_pkg::CMD_SET_PIN: begin
                    if (idx < FRAMES && valid[idx]) begin
                        if (cmd == bpcr_pkg::CMD_SET_DIRTY)
                            dirty[idx] = flag;
                        else
                            pinned[idx] = flag;
                    end
                    owe(bpcr_pkg::ST_DONE, idx, 1'b0, '0, '0, 1'b1);
                end
                bpcr_pkg::CMD_FLUSH_FRAME: begin
                    if (idx < FRAMES && dirty[idx]) begin
                        dirty[idx] = 1'b0;
                        owe(bpcr_pkg::ST_DONE, idx, 1'b1, file_tag[idx], block_tag[idx], 1'b1);
                    end else begin
                        owe(bpcr_pkg::ST_DONE, idx, 1'b0, '0, '0, 1'b1);
                    end
                end
                bpcr_pkg::CMD_FLUSH_ALL: begin
                    n = 0;
                    for (int i = 0; i < FRAMES; i++) begin
                        if (dirty[i]) begin
                            dirty[i] = 1'b0;
                            owe(bpcr_pkg::ST_DONE, i, 1'b1, file_tag[i], block_tag[i], 1'b0);
                            n++;
                        end
                    end
                    if (n == 0)
                        owe(bpcr_pkg::ST_DONE, 0, 1'b0, '0, '0, 1'b1);
                    else
                        owed_replies[owed_replies.size() - 1].last = 1'b1;
                end
                default: begin
                    owe(bpcr_pkg::ST_DONE, 0, 1'b0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest owed reply
        task check_reply(logic [bpcr_pkg::M_TDATA_W-1:0] data,
                         logic [bpcr_pkg::M_TUSER_W-1:0] user, logic last);
            t_reply want;
            t_reply got;
            got.status   = user[bpcr_pkg::STATUS_W-1:0];
            got.wb       = user[bpcr_pkg::STATUS_W];
            got.frame    = data[bpcr_pkg::IDX_W-1:0];
            got.wb_file  = data[bpcr_pkg::IDX_W +: bpcr_pkg::FILE_W];
            got.wb_block = data[bpcr_pkg::IDX_W+bpcr_pkg::FILE_W +: bpcr_pkg::BLOCK_W];
            got.last     = last;
            if (owed_replies.size() == 0) begin
                report($sformatf("result with none owed: status=%0d frame=%0d wb=%0b",
                                 got.status, got.frame, got.wb));
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status || got.frame !== want.frame ||
                got.wb !== want.wb || got.wb_file !== want.wb_file ||
                got.wb_block !== want.wb_block || got.last !== want.last)
                report($sformatf({"status %0d/%0d frame %0d/%0d wb %0b/%0b ",
                                  "file %h/%h block %h/%h last %0b/%0b (got/want)"},
                                 got.status, want.status, got.frame, want.frame,
                                 got.wb, want.wb, got.wb_file, want.wb_file,
                                 got.wb_block, want.wb_block, got.last, want.last));
        endtask
    endclass

    logic                                  i_clk         = 1'b0;
    logic                                  i_rst_n       = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic                                  s_axis_tready;
    logic [bpcr_pkg::S_TDATA_W-1:0]        s_axis_tdata  = '0;
    logic [bpcr_pkg::CMD_W-1:0]            s_axis_tuser  = bpcr_pkg::CMD_LOOKUP;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready = 1'b0;
    logic [bpcr_pkg::M_TDATA_W-1:0]        m_axis_tdata;
    logic [bpcr_pkg::M_TUSER_W-1:0]        m_axis_tuser;
    logic                                  m_axis_tlast;

    t_frame_table_model                    table_model;
    int                                    idle_pct = IDLE_PCT;
    logic [bpcr_pkg::FILE_W-1:0]           pool_fid[KEY_POOL];
    logic [bpcr_pkg::BLOCK_W-1:0]          pool_bid[KEY_POOL];

    buffer_pool_clock_replacement_unit #(
        .FRAMES (FRAMES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stall the result side at random and check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_reply(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Offer one request, with a random gap first, and hold it until taken
    task automatic send_request(logic [bpcr_pkg::CMD_W-1:0] cmd,
                                logic [bpcr_pkg::FILE_W-1:0] fid,
                                logic [bpcr_pkg::BLOCK_W-1:0] bid,
                                logic [bpcr_pkg::IDX_W-1:0] idx,
                                logic flag);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bpcr_pkg::S_TDATA_W - REQ_FIELDS_W){1'b0}}, flag, idx, bid, fid};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        table_model.note_request(cmd, fid, bid, idx, flag);
    endtask

    // Pin all frames or a random part of them, ask for a new block, then unpin them all
    task automatic pin_sweep(bit pin_all);
        for (int i = 0; i < FRAMES; i++)
            send_request(bpcr_pkg::CMD_SET_PIN, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'(i),
                         pin_all ? 1'b1 : 1'($urandom_range(0, 3) != 0));
        send_request(bpcr_pkg::CMD_LOOKUP, bpcr_pkg::FILE_W'($urandom()),
                     bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'($urandom()),
                     1'($urandom()));
        for (int i = 0; i < FRAMES; i++)
            send_request(bpcr_pkg::CMD_SET_PIN, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'(i), 1'b0);
    endtask

    task automatic random_request();
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, KEY_POOL - 1);
        if (r < 55) begin
            send_request(bpcr_pkg::CMD_LOOKUP, pool_fid[k], pool_bid[k],
                         bpcr_pkg::IDX_W'($urandom()), 1'($urandom()));
        end else if (r < 65) begin
            send_request(bpcr_pkg::CMD_SET_DIRTY, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'($urandom()),
                         1'($urandom_range(0, 3) != 0));
        end else if (r < 72) begin
            send_request(bpcr_pkg::CMD_SET_PIN, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'($urandom()),
                         1'($urandom_range(0, 2) == 0));
        end else if (r < 80) begin
            send_request(bpcr_pkg::CMD_FLUSH_FRAME, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'($urandom()),
                         1'($urandom()));
        end else if (r < 84) begin
            send_request(bpcr_pkg::CMD_FLUSH_ALL, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'($urandom()),
                         1'($urandom()));
        end else if (r < 87) begin
            send_request(bpcr_pkg::CMD_W'($urandom_range(CMD_RESERVED_FIRST,
                                                         CMD_RESERVED_LAST)),
                         bpcr_pkg::FILE_W'($urandom()), bpcr_pkg::BLOCK_W'($urandom()),
                         bpcr_pkg::IDX_W'($urandom()), 1'($urandom()));
        end else if (r < 95) begin
            // Stray block, almost surely absent from the table
            send_request(bpcr_pkg::CMD_LOOKUP, bpcr_pkg::FILE_W'($urandom()),
                         bpcr_pkg::BLOCK_W'($urandom()), bpcr_pkg::IDX_W'($urandom()),
                         1'($urandom()));
        end else begin
            // Retire one block of the working set for a fresh one
            pool_fid[k] = bpcr_pkg::FILE_W'($urandom());
            pool_bid[k] = bpcr_pkg::BLOCK_W'($urandom());
            send_request(bpcr_pkg::CMD_LOOKUP, pool_fid[k], pool_bid[k],
                         bpcr_pkg::IDX_W'($urandom()), 1'($urandom()));
        end
    endtask

    initial begin
        table_model = new();
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_fid[i] = bpcr_pkg::FILE_W'($urandom());
            pool_bid[i] = bpcr_pkg::BLOCK_W'($urandom());
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fills, hit, flag changes on valid and empty frames, flushes
        send_request(bpcr_pkg::CMD_LOOKUP, '0, '0, '0, 1'b0);
        send_request(bpcr_pkg::CMD_LOOKUP, '1, '1, '1, 1'b1);
        send_request(bpcr_pkg::CMD_LOOKUP, '0, '0, '1, 1'b1);
        send_request(bpcr_pkg::CMD_SET_DIRTY, '0, '0, bpcr_pkg::IDX_W'(0), 1'b1);
        send_request(bpcr_pkg::CMD_SET_DIRTY, '1, '1, bpcr_pkg::IDX_W'(FRAMES - 1), 1'b1);
        send_request(bpcr_pkg::CMD_SET_PIN, '0, '0, bpcr_pkg::IDX_W'(1), 1'b1);
        send_request(bpcr_pkg::CMD_SET_PIN, '0, '0, bpcr_pkg::IDX_W'(FRAMES - 2), 1'b1);
        send_request(bpcr_pkg::CMD_FLUSH_FRAME, '0, '0, bpcr_pkg::IDX_W'(0), 1'b0);
        send_request(bpcr_pkg::CMD_FLUSH_FRAME, '0, '0, bpcr_pkg::IDX_W'(1), 1'b0);
        send_request(bpcr_pkg::CMD_FLUSH_FRAME, '0, '0, bpcr_pkg::IDX_W'(FRAMES - 1), 1'b0);
        send_request(bpcr_pkg::CMD_SET_DIRTY, '0, '0, bpcr_pkg::IDX_W'(1), 1'b1);
        send_request(bpcr_pkg::CMD_SET_DIRTY, '0, '0, bpcr_pkg::IDX_W'(0), 1'b1);
        send_request(bpcr_pkg::CMD_FLUSH_ALL, '0, '0, '0, 1'b0);
        send_request(bpcr_pkg::CMD_FLUSH_ALL, '1, '1, '1, 1'b1);
        send_request(bpcr_pkg::CMD_SET_DIRTY, '0, '0, bpcr_pkg::IDX_W'(0), 1'b1);
        send_request(bpcr_pkg::CMD_SET_DIRTY, '0, '0, bpcr_pkg::IDX_W'(0), 1'b0);
        send_request(bpcr_pkg::CMD_FLUSH_FRAME, '0, '0, bpcr_pkg::IDX_W'(0), 1'b0);
        send_request(bpcr_pkg::CMD_SET_PIN, '0, '0, bpcr_pkg::IDX_W'(1), 1'b0);
        for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
            send_request(bpcr_pkg::CMD_W'(c), '1, '1, '1, 1'b1);
        send_request(bpcr_pkg::CMD_LOOKUP, bpcr_pkg::FILE_W'('h5a),
                     bpcr_pkg::BLOCK_W'('ha5a5), '0, 1'b0);

        // Random: working-set lookups mixed with flag changes, flushes and two pin sweeps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= CALM_FIRST && n < CALM_LAST) ? 0 : IDLE_PCT;
            if (n == 90)
                pin_sweep(1'b1);
            else if (n == 220)
                pin_sweep(1'b0);
            else
                random_request();
        end
        s_axis_tvalid <= 1'b0;

        // Drain the owed replies, then let the block settle
        while (table_model.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_model.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
